// ===== rtl/core/tsco_pkg.sv =====
// Package for the tanh soft-clip overdrive: payload widths, fixed-point
// constants, register index codes and the pipeline sideband type.
// Depends on nothing; used by the channel interfaces and the top level.
package tsco_pkg;

   localparam int SAMPLE_W = 16;
   localparam int CFG_W = 16;
   localparam int MAG_W = 17;
   localparam int LQ_W = 17;
   localparam int DQ_W = 22;
   localparam int PROD_W = DQ_W + MAG_W;
   localparam int TBL_W = 16;
   localparam int FRAC_W = 16;
   localparam int SAT_BIT = 35;
   localparam int POS_SHIFT = 19;
   localparam int PIPE_STAGES = 7;

   localparam logic [LQ_W-1:0] LQ_BASE = 17'd6554;
   localparam logic [15:0] LQ_SCALE = 16'd58982;
   localparam logic [DQ_W-1:0] DQ_BASE = 22'd65536;
   localparam logic [5:0] DQ_SCALE = 6'd50;
   localparam logic [15:0] ROUND_HALF = 16'd32767;
   localparam logic [TBL_W-1:0] TANH_ONE = 16'd32768;
   localparam logic [14:0] OUT_MAX = 15'd32767;
   localparam logic [63:0] Q30_ONE = 64'd1073741824;

   typedef enum logic [1:0] {
      CSR_SWITCH = 2'd0,
      CSR_LEVEL  = 2'd1,
      CSR_DRIVE  = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic             active;
      logic             neg;
      logic [MAG_W-1:0] mag;
   } side_type;

endpackage

// ===== rtl/core/tsco_req_if.sv =====
// Input channel of the overdrive: valid/ready handshake with one sample.
// Depends on tsco_pkg for the payload width.
interface tsco_req_if import tsco_pkg::*; ;
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample_in;

   modport source (output valid, output sample_in, input ready);
   modport sink (input valid, input sample_in, output ready);
endinterface

// ===== rtl/core/tsco_rsp_if.sv =====
// Result channel of the overdrive: valid/ready handshake with the shaped
// sample and the active flag. Depends on tsco_pkg for the payload width.
interface tsco_rsp_if import tsco_pkg::*; ;
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample_out;
   logic                       effect_active;

   modport source (output valid, output sample_out, output effect_active, input ready);
   modport sink (input valid, input sample_out, input effect_active, output ready);
endinterface

// ===== rtl/core/tanh_soft_clip_overdrive.sv =====
// Tanh soft-clip overdrive: seven-stage pipeline with an interpolated tanh table.
// Depends on tsco_pkg, tsco_req_if and tsco_rsp_if.
//
//   Channel   Direction   Handshake            Payload
//   req_ch    in          valid/ready          sample_in
//   rsp_ch    out         valid/ready          sample_out, effect_active
//   csr_*     in          csr_we, no wait      csr_index, csr_wdata
//
// One transaction enters per cycle while req_ch.ready is high. The depth is
// set by the chain input register, abs/drive multiply, table position, table
// read, interpolation, level multiply and sign stage. Each stage holds while
// the next one is full and stalled, so empty stages still take transactions.
// Synchronous reset clears valid bits and switch, sets gains to LQ_BASE/DQ_BASE.
module tanh_soft_clip_overdrive import tsco_pkg::*; #(
   parameter int TANH_SEGMENTS = 256
) (
   input  logic                 clock,
   input  logic                 reset,
   tsco_req_if.sink             req_ch,
   tsco_rsp_if.source           rsp_ch,
   input  logic                 csr_we,
   input  logic [1:0]           csr_index,
   input  logic [CFG_W-1:0]     csr_wdata
);

   localparam int IDX_W = $clog2(TANH_SEGMENTS);
   localparam int SEG_W = $clog2(TANH_SEGMENTS + 1);
   localparam int SCL_W = SAT_BIT + SEG_W;
   localparam int POS_W = IDX_W + FRAC_W;

   typedef logic [TBL_W-1:0] rom_type [TANH_SEGMENTS];

   function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
      logic [64:0] rem;
      logic [63:0] q;
      rem = '0;
      q = '0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[63:0], n[b]};
         if (rem >= {1'b0, d}) begin
            rem = rem - {1'b0, d};
            q[b] = 1'b1;
         end
      end
      return q;
   endfunction

   function automatic rom_type build_rom(input logic want_diff);
      logic [63:0] term;
      logic [63:0] plus;
      logic [63:0] minus;
      logic [63:0] e;
      logic [63:0] h;
      logic [63:0] t;
      logic [63:0] den;
      logic [63:0] v;
      logic [63:0] prev;
      rom_type     rom;
      term = Q30_ONE;
      plus = Q30_ONE;
      minus = '0;
      for (int i = 1; i < 64; i++) begin
         if (term != 0) begin
            term = udiv64(term * 64'd16, 64'(TANH_SEGMENTS) * 64'(i));
            if (i % 2 == 1) begin
               minus = minus + term;
            end else begin
               plus = plus + term;
            end
         end
      end
      e = plus - minus;
      h = udiv64(((Q30_ONE - e) << 30) + ((Q30_ONE + e) >> 1), Q30_ONE + e);
      t = '0;
      prev = '0;
      for (int k = 0; k <= TANH_SEGMENTS; k++) begin
         v = (t + 64'd16384) >> 15;
         if (v > 64'(TANH_ONE)) begin
            v = 64'(TANH_ONE);
         end
         if (!want_diff && k < TANH_SEGMENTS) begin
            rom[k] = v[TBL_W-1:0];
         end
         if (want_diff && k > 0) begin
            rom[k-1] = (v >= prev) ? TBL_W'(v - prev) : '0;
         end
         prev = v;
         den = Q30_ONE + ((t * h + (Q30_ONE >> 1)) >> 30);
         t = udiv64(((t + h) << 30) + (den >> 1), den);
      end
      return rom;
   endfunction

   localparam rom_type TANH_LO = build_rom(1'b0);
   localparam rom_type TANH_DF = build_rom(1'b1);

   // Knob registers, kept in their derived gain form.
   logic              on_ff;
   logic [LQ_W-1:0]   lq_ff;
   logic [DQ_W-1:0]   dq_ff;
   logic [LQ_W-1:0]   lq_in;
   logic [DQ_W-1:0]   dq_in;
   logic [31:0]       lvl_num;
   logic [32:0]       lvl_sum;
   logic [DQ_W-1:0]   drv_mul;
   logic [DQ_W:0]     drv_num;
   logic [DQ_W:0]     drv_sum;

   always_comb begin
      lvl_num = 32'(csr_wdata) * 32'(LQ_SCALE) + 32'(ROUND_HALF);
      lvl_sum = 33'(lvl_num) + 33'(lvl_num >> 16) + 33'd1;
      lq_in = LQ_BASE + LQ_W'(lvl_sum >> 16);
      drv_mul = DQ_W'(csr_wdata) * DQ_W'(DQ_SCALE);
      drv_num = (DQ_W+1)'(drv_mul) + (DQ_W+1)'(ROUND_HALF);
      drv_sum = drv_num + (drv_num >> 16) + (DQ_W+1)'(1);
      dq_in = DQ_BASE + drv_mul + DQ_W'(drv_sum >> 16);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         on_ff <= 1'b0;
         lq_ff <= LQ_BASE;
         dq_ff <= DQ_BASE;
      end else if (csr_we) begin
         case (csr_index)
            CSR_SWITCH: on_ff <= csr_wdata[CFG_W-1];
            CSR_LEVEL:  lq_ff <= lq_in;
            CSR_DRIVE:  dq_ff <= dq_in;
            default: ;
         endcase
      end
   end

   // Pipeline flow control.
   logic [PIPE_STAGES:1] v_ff;
   logic [PIPE_STAGES:1] en;

   always_comb begin
      en[PIPE_STAGES] = !v_ff[PIPE_STAGES] || rsp_ch.ready;
      for (int k = PIPE_STAGES - 1; k >= 1; k--) begin
         en[k] = !v_ff[k] || en[k+1];
      end
   end

   assign req_ch.ready = en[1];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (en[1]) begin
            v_ff[1] <= req_ch.valid;
         end
         for (int k = 2; k <= PIPE_STAGES; k++) begin
            if (en[k]) begin
               v_ff[k] <= v_ff[k-1];
            end
         end
      end
   end

   // Datapath registers.
   logic signed [SAMPLE_W-1:0] s1_ff;
   logic                       on1_ff;
   side_type                   side_ff [2:PIPE_STAGES];
   logic [PROD_W-1:0]          p2_ff;
   logic                       sat3_ff;
   logic [POS_W-1:0]           pos3_ff;
   logic                       sat4_ff;
   logic [FRAC_W-1:0]          frac4_ff;
   logic [TBL_W-1:0]           lo4_ff;
   logic [TBL_W-1:0]           df4_ff;
   logic [TBL_W-1:0]           t5_ff;
   logic [14:0]                m6_ff;
   logic signed [SAMPLE_W-1:0] out7_ff;

   side_type                   side2_in;
   logic [PROD_W-1:0]          p2_in;
   logic [SCL_W-1:0]           scaled_in;
   logic [POS_W-1:0]           pos3_in;
   logic [IDX_W-1:0]           idx3;
   logic [32:0]                interp;
   logic [TBL_W-1:0]           t5_in;
   logic [LQ_W+TBL_W:0]        lvl_prod;
   logic [LQ_W+TBL_W:0]        m_full;
   logic [14:0]                m6_in;
   logic [14:0]                byp_mag;
   logic [14:0]                sel_mag;
   logic signed [SAMPLE_W-1:0] out7_in;

   always_comb begin
      side2_in.active = on1_ff;
      side2_in.neg = s1_ff[SAMPLE_W-1];
      side2_in.mag = s1_ff[SAMPLE_W-1] ? (MAG_W'(0) - MAG_W'(s1_ff)) : MAG_W'(s1_ff);
      p2_in = PROD_W'(dq_ff) * PROD_W'(side2_in.mag);

      scaled_in = SCL_W'(p2_ff[SAT_BIT-1:0]) * SCL_W'(TANH_SEGMENTS);
      pos3_in = scaled_in[POS_SHIFT +: POS_W];
      idx3 = pos3_ff[FRAC_W +: IDX_W];

      interp = 33'(df4_ff) * 33'(frac4_ff) + 33'(TANH_ONE);
      t5_in = sat4_ff ? TANH_ONE : (lo4_ff + TBL_W'(interp >> 16));

      lvl_prod = (LQ_W+TBL_W+1)'(lq_ff) * (LQ_W+TBL_W+1)'(t5_ff);
      m_full = (lvl_prod + (LQ_W+TBL_W+1)'(TANH_ONE)) >> 16;
      m6_in = (m_full > (LQ_W+TBL_W+1)'(OUT_MAX)) ? OUT_MAX : m_full[14:0];

      byp_mag = (side_ff[PIPE_STAGES-1].mag > MAG_W'(OUT_MAX)) ? OUT_MAX
                                                             : side_ff[PIPE_STAGES-1].mag[14:0];
      sel_mag = side_ff[PIPE_STAGES-1].active ? m6_ff : byp_mag;
      out7_in = side_ff[PIPE_STAGES-1].neg ? -$signed({1'b0, sel_mag})
                                           : $signed({1'b0, sel_mag});
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         s1_ff <= req_ch.sample_in;
         on1_ff <= on_ff;
      end
      if (en[2]) begin
         side_ff[2] <= side2_in;
         p2_ff <= p2_in;
      end
      if (en[3]) begin
         sat3_ff <= |p2_ff[PROD_W-1:SAT_BIT];
         pos3_ff <= pos3_in;
      end
      if (en[4]) begin
         sat4_ff <= sat3_ff;
         frac4_ff <= pos3_ff[FRAC_W-1:0];
         lo4_ff <= TANH_LO[idx3];
         df4_ff <= TANH_DF[idx3];
      end
      if (en[5]) begin
         t5_ff <= t5_in;
      end
      if (en[6]) begin
         m6_ff <= m6_in;
      end
      if (en[7]) begin
         out7_ff <= out7_in;
      end
      for (int k = 3; k <= PIPE_STAGES; k++) begin
         if (en[k]) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   assign rsp_ch.valid = v_ff[PIPE_STAGES];
   assign rsp_ch.sample_out = out7_ff;
   assign rsp_ch.effect_active = side_ff[PIPE_STAGES].active;

   a_accept_enters : assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> v_ff[1])
      else $error("Accepted transaction did not enter the first stage.");

   a_full_stall : assert property (@(posedge clock) disable iff (reset)
      (&v_ff && !rsp_ch.ready) |-> !req_ch.ready)
      else $error("Input accepted while the full pipeline is stalled.");

   a_gain_range : assert property (@(posedge clock) disable iff (reset)
      (lq_ff >= LQ_BASE) && (lq_ff <= 17'd65536) && (dq_ff >= DQ_BASE)
      && (dq_ff <= 22'd3342336))
      else $error("Derived level or drive gain out of range.");

   a_out_sat : assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (rsp_ch.sample_out != 16'sh8000))
      else $error("Result transaction not saturated to 32767.");

endmodule
